/* hdl/lzo_pkg.sv */
// ----------------------------------------------------------------------------
// LZO1X stream decompressor package
// Shared payload types, result and status codes, and the decoder phases.
// ----------------------------------------------------------------------------
package lzo_pkg;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_REFUSED = 2'd2;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_LEFT  = 3'd1;
   localparam logic [2:0] ST_SHORT = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_LOOK  = 3'd4;
   localparam logic [2:0] ST_OVER  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam logic [7:0]  FIRST_LIT_BASE = 8'h11;
   localparam logic [7:0]  TOK_MATCH_MIN  = 8'h10;
   localparam logic [7:0]  TOK_M3_MIN     = 8'h20;
   localparam logic [7:0]  TOK_M2_MIN     = 8'h40;
   localparam logic [15:0] M1_SHORT_BASE  = 16'h0801;
   localparam logic [15:0] M4_BASE        = 16'h4000;
   localparam logic [32:0] EXT_ZERO_ADD   = 33'h0FF;
   localparam logic [32:0] M3_EXT_ADD     = 33'h01F;

   localparam logic [31:0] DEST_LIMIT_RESET = 32'hFFFF_FFFF;

   typedef enum logic [11:0] {
      PH_FIRST      = 12'b0000_0000_0001,
      PH_TOKEN      = 12'b0000_0000_0010,
      PH_LIT_EXT    = 12'b0000_0000_0100,
      PH_LIT        = 12'b0000_0000_1000,
      PH_LIT_NEXT   = 12'b0000_0001_0000,
      PH_MATCH_EXT  = 12'b0000_0010_0000,
      PH_OFF_LO     = 12'b0000_0100_0000,
      PH_OFF_HI     = 12'b0000_1000_0000,
      PH_OFF_ONE    = 12'b0001_0000_0000,
      PH_COPY       = 12'b0010_0000_0000,
      PH_MATCH_DONE = 12'b0100_0000_0000,
      PH_SKIP       = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [2:0]  status;
      logic [31:0] byte_total;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      logic            use_ram;
      logic            wr_en;
      rsp_payload_type payload;
   } step_type;

endpackage

/* hdl/lzo_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lzo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lzo_ctrl.sv */
// ----------------------------------------------------------------------------
// LZO1X token decoder
// Holds the decoder state and works out the result and history access of
// each accepted transaction.
// ----------------------------------------------------------------------------
module lzo_ctrl #(
   parameter int AW = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  lzo_pkg::req_payload_type req,
   input  logic                     csr_write,
   input  logic [31:0]              csr_data,
   output lzo_pkg::step_type        step,
   output logic [AW-1:0]            rd_addr,
   output logic [AW-1:0]            wr_addr
);

   logic [31:0]        limit_ff, out_ff, in_ff, run_ff;
   lzo_pkg::phase_type ph_ff;
   logic [7:0]         tok_ff, p0_ff, p1_ff, olo_ff;
   logic [15:0]        dist_ff;
   logic               ended_ff, lallow_ff, short_ff;

   logic [31:0]        n_out, n_in, n_run;
   lzo_pkg::phase_type n_ph;
   logic [7:0]         n_tok, n_p0, n_p1, n_olo;
   logic [15:0]        n_dist;
   logic               n_ended, n_lallow, n_short;

   logic [31:0] room, back_addr;
   logic [2:0]  st;
   logic        emit, do_lt, do_bm, do_sl, sl_allow, do_sc;
   logic [7:0]  v, t, bm_tok;
   logic [32:0] sum;
   logic [15:0] off, base, sc_dist;

   assign room      = (out_ff <= limit_ff) ? (limit_ff - out_ff) : '0;
   assign back_addr = out_ff - {16'b0, dist_ff};
   assign rd_addr   = back_addr[AW-1:0];
   assign wr_addr   = out_ff[AW-1:0];
   assign v         = req.in_byte;

   always_comb begin
      n_out = out_ff; n_in = in_ff; n_run = run_ff; n_ph = ph_ff;
      n_tok = tok_ff; n_p0 = p0_ff; n_p1 = p1_ff; n_olo = olo_ff;
      n_dist = dist_ff; n_ended = ended_ff; n_lallow = lallow_ff; n_short = short_ff;
      st = lzo_pkg::ST_OK; emit = 1'b0;
      do_lt = 1'b0; do_bm = 1'b0; do_sl = 1'b0; sl_allow = 1'b0; do_sc = 1'b0;
      bm_tok = '0; sum = '0; off = '0; base = '0; sc_dist = '0;
      t = tok_ff;
      step = '0;

      if (accept) begin
         if (ph_ff == lzo_pkg::PH_MATCH_DONE) begin
            if (ended_ff) begin
               st = lzo_pkg::ST_SHORT; emit = 1'b1;
            end else if (p1_ff[1:0] == 2'd0) begin
               n_ph = lzo_pkg::PH_TOKEN;
            end else begin
               n_run = {30'b0, p1_ff[1:0]};
               if (n_run > room) begin
                  st = lzo_pkg::ST_FULL; emit = 1'b1;
               end else begin
                  n_lallow = 1'b0; n_ph = lzo_pkg::PH_LIT;
               end
            end
         end

         if (req.req_type == lzo_pkg::REQ_TICK) begin
            if (ph_ff == lzo_pkg::PH_COPY) begin
               step.valid = 1'b1; step.use_ram = 1'b1; step.wr_en = 1'b1;
               step.payload.kind = lzo_pkg::KIND_BYTE;
               n_out = out_ff + 32'd1;
               n_run = run_ff - 32'd1;
               if (run_ff == 32'd1) n_ph = lzo_pkg::PH_MATCH_DONE;
            end
         end else if (ph_ff == lzo_pkg::PH_COPY) begin
            step.valid = 1'b1;
            step.payload.kind = lzo_pkg::KIND_REFUSED;
         end else if (!emit) begin
            if (in_ff == 32'hFFFF_FFFF) begin
               st = lzo_pkg::ST_OVER; emit = 1'b1;
            end else begin
               n_in = in_ff + 32'd1;
               n_p1 = p0_ff;
               n_p0 = v;
               if (n_ph == lzo_pkg::PH_SKIP) begin
                  if (req.last_byte) begin
                     st = lzo_pkg::ST_LEFT; emit = 1'b1;
                  end
               end else if (n_ph == lzo_pkg::PH_LIT && req.last_byte) begin
                  st = lzo_pkg::ST_SHORT; emit = 1'b1;
               end else begin
                  unique case (n_ph)
                     lzo_pkg::PH_FIRST: begin
                        if (v > lzo_pkg::FIRST_LIT_BASE) begin
                           n_run = {24'b0, v - lzo_pkg::FIRST_LIT_BASE};
                           do_sl = 1'b1;
                           sl_allow = (n_run >= 32'd4);
                        end else begin
                           do_lt = 1'b1;
                        end
                     end
                     lzo_pkg::PH_TOKEN: do_lt = 1'b1;
                     lzo_pkg::PH_LIT_EXT: begin
                        if (v == 8'd0) sum = {1'b0, n_run} + lzo_pkg::EXT_ZERO_ADD;
                        else sum = {1'b0, n_run} + {25'b0, v} + 33'h12;
                        if (sum[32]) begin
                           st = lzo_pkg::ST_OVER;
                        end else begin
                           n_run = sum[31:0];
                           if (v != 8'd0) begin
                              do_sl = 1'b1; sl_allow = 1'b1;
                           end
                        end
                     end
                     lzo_pkg::PH_LIT: begin
                        step.valid = 1'b1; step.wr_en = 1'b1;
                        step.payload.kind = lzo_pkg::KIND_BYTE;
                        step.payload.out_byte = v;
                        n_out = out_ff + 32'd1;
                        n_run = n_run - 32'd1;
                        if (n_run == 32'd0) n_ph = lzo_pkg::PH_LIT_NEXT;
                     end
                     lzo_pkg::PH_LIT_NEXT: begin
                        if (lallow_ff && v < lzo_pkg::TOK_MATCH_MIN) begin
                           n_tok = v; n_short = 1'b1; n_ph = lzo_pkg::PH_OFF_ONE;
                        end else begin
                           do_bm = 1'b1; bm_tok = v;
                        end
                     end
                     lzo_pkg::PH_MATCH_EXT: begin
                        if (v == 8'd0) sum = {1'b0, n_run} + lzo_pkg::EXT_ZERO_ADD;
                        else if (t >= lzo_pkg::TOK_M3_MIN)
                           sum = {1'b0, n_run} + {25'b0, v} + lzo_pkg::M3_EXT_ADD;
                        else sum = {1'b0, n_run} + {25'b0, v} + 33'd7;
                        if (sum[32]) begin
                           st = lzo_pkg::ST_OVER;
                        end else begin
                           n_run = sum[31:0];
                           if (v != 8'd0) n_ph = lzo_pkg::PH_OFF_LO;
                        end
                     end
                     lzo_pkg::PH_OFF_LO: begin
                        n_olo = v; n_ph = lzo_pkg::PH_OFF_HI;
                     end
                     lzo_pkg::PH_OFF_HI: begin
                        off = {v, olo_ff};
                        if (t >= lzo_pkg::TOK_M3_MIN) begin
                           sc_dist = {2'b0, off[15:2]} + 16'd1;
                           do_sc = 1'b1;
                        end else begin
                           base = (t[3] ? lzo_pkg::M4_BASE : 16'd0) + {2'b0, off[15:2]};
                           if (base == 16'd0) begin
                              st = lzo_pkg::ST_DONE;
                           end else begin
                              sc_dist = base + lzo_pkg::M4_BASE;
                              do_sc = 1'b1;
                           end
                        end
                        if (do_sc) begin
                           sum = {1'b0, n_run} + 33'd2;
                           if (sum[32]) begin
                              st = lzo_pkg::ST_OVER; do_sc = 1'b0;
                           end else begin
                              n_run = sum[31:0];
                           end
                        end
                     end
                     lzo_pkg::PH_OFF_ONE: begin
                        if (short_ff) begin
                           n_run = 32'd3;
                           sc_dist = lzo_pkg::M1_SHORT_BASE + {6'b0, v, 2'b0}
                                     + {10'b0, t[7:2]};
                        end else if (t >= lzo_pkg::TOK_M2_MIN) begin
                           n_run = {29'b0, t[7:5]} + 32'd1;
                           sc_dist = {5'b0, v, 3'b0} + 16'd1 + {13'b0, t[4:2]};
                        end else begin
                           n_run = 32'd2;
                           sc_dist = {6'b0, v, 2'b0} + {10'b0, t[7:2]} + 16'd1;
                        end
                        do_sc = 1'b1;
                     end
                     default: ;
                  endcase

                  if (do_lt) begin
                     if (v >= lzo_pkg::TOK_MATCH_MIN) begin
                        do_bm = 1'b1; bm_tok = v;
                     end else if (v == 8'd0) begin
                        n_run = '0; n_ph = lzo_pkg::PH_LIT_EXT;
                     end else begin
                        n_run = {24'b0, v} + 32'd3;
                        do_sl = 1'b1; sl_allow = 1'b1;
                     end
                  end
                  if (do_bm) begin
                     n_tok = bm_tok; n_short = 1'b0;
                     if (bm_tok >= lzo_pkg::TOK_M2_MIN || bm_tok < lzo_pkg::TOK_MATCH_MIN) begin
                        n_ph = lzo_pkg::PH_OFF_ONE;
                     end else begin
                        if (bm_tok >= lzo_pkg::TOK_M3_MIN) n_run = {27'b0, bm_tok[4:0]};
                        else n_run = {29'b0, bm_tok[2:0]};
                        n_ph = (n_run != 32'd0) ? lzo_pkg::PH_OFF_LO : lzo_pkg::PH_MATCH_EXT;
                     end
                  end
                  if (do_sl) begin
                     if (n_run > room) begin
                        st = lzo_pkg::ST_FULL;
                     end else begin
                        n_lallow = sl_allow; n_ph = lzo_pkg::PH_LIT;
                     end
                  end
                  if (do_sc) begin
                     if (sc_dist == 16'd0 || {16'b0, sc_dist} > out_ff) begin
                        st = lzo_pkg::ST_LOOK;
                     end else if (n_run > room) begin
                        st = lzo_pkg::ST_FULL;
                     end else begin
                        n_dist = sc_dist; n_ph = lzo_pkg::PH_COPY;
                     end
                  end

                  if (st == lzo_pkg::ST_DONE) begin
                     if (req.last_byte) begin
                        st = lzo_pkg::ST_OK; emit = 1'b1;
                     end else begin
                        n_ph = lzo_pkg::PH_SKIP;
                     end
                  end else if (st != lzo_pkg::ST_OK) begin
                     emit = 1'b1;
                  end else if (req.last_byte) begin
                     if (n_ph == lzo_pkg::PH_COPY) begin
                        n_ended = 1'b1;
                     end else begin
                        st = lzo_pkg::ST_SHORT; emit = 1'b1;
                     end
                  end
               end
            end
         end
      end

      if (emit) begin
         step = '0;
         step.valid = 1'b1;
         step.payload.kind = lzo_pkg::KIND_STATUS;
         step.payload.status = st;
         step.payload.byte_total = n_out;
         n_out = '0; n_in = '0; n_run = '0; n_ph = lzo_pkg::PH_FIRST;
         n_tok = '0; n_p0 = '0; n_p1 = '0; n_olo = '0; n_dist = '0;
         n_ended = 1'b0; n_lallow = 1'b0; n_short = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lzo_pkg::DEST_LIMIT_RESET;
         out_ff <= '0; in_ff <= '0; run_ff <= '0; ph_ff <= lzo_pkg::PH_FIRST;
         tok_ff <= '0; p0_ff <= '0; p1_ff <= '0; olo_ff <= '0; dist_ff <= '0;
         ended_ff <= 1'b0; lallow_ff <= 1'b0; short_ff <= 1'b0;
      end else begin
         if (csr_write) limit_ff <= csr_data;
         out_ff <= n_out; in_ff <= n_in; run_ff <= n_run; ph_ff <= n_ph;
         tok_ff <= n_tok; p0_ff <= n_p0; p1_ff <= n_p1; olo_ff <= n_olo;
         dist_ff <= n_dist; ended_ff <= n_ended; lallow_ff <= n_lallow;
         short_ff <= n_short;
      end
   end

endmodule

/* hdl/lzo1x_stream_decompressor_top.sv */
// ----------------------------------------------------------------------------
// LZO1X stream decompressor
// The req channel carries compressed bytes and drain ticks, one per
// transaction. The rsp channel returns decoded bytes, end status and
// refusals. The csr channel writes the destination limit and is always ready.
// Each request is decoded in the cycle it is accepted; any result is shown in
// the cycle after from the output register. One request can be accepted
// every cycle unless a result stalls. A match byte is read from the history
// RAM in the accept cycle and written back in the next, with forwarding when
// a copy reads the byte written just before it. Every match byte costs one
// tick transaction; literal bytes come out of their own byte transactions.
// When the receiver stalls, the held result stays on rsp and req_ready drops
// until it is taken. Reset clears the decoder and result stage and sets the
// limit to all ones; the history RAM is not cleared and needs no clearing
// pass.
// ----------------------------------------------------------------------------
module lzo1x_stream_decompressor_top #(
   parameter int HISTORY_DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lzo_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output lzo_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [31:0]              csr_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   lzo_pkg::step_type        step;
   lzo_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     use_ram_ff, use_ram_in, wr_en_ff, wr_en_in;
   logic                     fwd_ff, fwd_in;
   logic [7:0]               fwd_data_ff, fwd_data_in;
   logic [AW-1:0]            waddr_ff, waddr_in, rd_addr, wr_addr;
   logic [7:0]               ram_q, cur_byte;
   logic                     accept, load;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign load      = accept && step.valid;

   lzo_ctrl #(.AW(AW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .step      (step),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   lzo_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_addr (waddr_ff),
      .wr_data (cur_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign cur_byte = use_ram_ff ? (fwd_ff ? fwd_data_ff : ram_q) : rsp_ff.out_byte;

   always_comb begin
      rsp_in = rsp_ff;
      rsp_in.out_byte = cur_byte;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_in = step.payload;
         rsp_valid_in = 1'b1;
      end
      use_ram_in  = accept && step.use_ram;
      wr_en_in    = load && step.wr_en;
      waddr_in    = wr_addr;
      fwd_in      = wr_en_ff && (waddr_ff == rd_addr);
      fwd_data_in = cur_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         use_ram_ff   <= 1'b0;
         wr_en_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         use_ram_ff   <= use_ram_in;
         wr_en_ff     <= wr_en_in;
      end
      rsp_ff      <= rsp_in;
      waddr_ff    <= waddr_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
   end

   always_comb begin
      rsp_payload = rsp_ff;
      rsp_payload.out_byte = cur_byte;
   end
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/lzo_chk.sv */
// ----------------------------------------------------------------------------
// LZO1X stream decompressor checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lzo_chk (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input lzo_pkg::rsp_payload_type rsp_payload
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result is valid right after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result transaction changed.");

   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == lzo_pkg::KIND_BYTE |->
      rsp_payload.status == lzo_pkg::ST_OK && rsp_payload.byte_total == 32'd0)
      else $error("Decoded byte carries status fields.");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.kind <= lzo_pkg::KIND_REFUSED &&
      (rsp_payload.kind != lzo_pkg::KIND_STATUS || rsp_payload.status <= lzo_pkg::ST_OVER))
      else $error("Result kind or status code out of range.");

   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Request taken while a result is stalled.");

endmodule

bind lzo1x_stream_decompressor_top lzo_chk u_lzo_chk (.*);
